[rtl/gbe_pkg.sv]
package gbe_pkg;

   // Default store depth in bytes
   localparam int BUFFER_SIZE_DEF = 1024;

   // Field widths of the item and result ports
   localparam int CMD_W   = 4;
   localparam int CHAR_W  = 8;
   localparam int FIELD_W = 11;

   // Command codes; codes above CLEAR_DIRTY are ignored
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT      = 4'd0,
      CMD_BACKSPACE   = 4'd1,
      CMD_LEFT        = 4'd2,
      CMD_RIGHT       = 4'd3,
      CMD_LEFT_N      = 4'd4,
      CMD_RIGHT_N     = 4'd5,
      CMD_LEFT_UNTIL  = 4'd6,
      CMD_RIGHT_UNTIL = 4'd7,
      CMD_CLEAR_DIRTY = 4'd8
   } command_type;

endpackage

[rtl/gbe_text_ram.sv]
module gbe_text_ram #(
   parameter int DEPTH = gbe_pkg::BUFFER_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [gbe_pkg::CHAR_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [gbe_pkg::CHAR_W-1:0]  rd_data
);

   logic [gbe_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [gbe_pkg::CHAR_W-1:0] rd_data_ff;

   // Write one byte, read one byte with a registered result
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/gap_buffer_editor.sv]
// Gap-buffer text store with a single-port-read, single-port-write byte memory.
// Insert, backspace, clear and unknown commands: result in the cycle after accept.
// Cursor moves carry each byte across the gap by a memory read and then a
// write-back; a move with no step to take gives its result like an insert.
// The next item is taken in the cycle that shows the result; results cannot stall.
// Synchronous reset empties the text (cursor 0, gap spans the store, clean).
module gap_buffer_editor #(
   parameter int BUFFER_SIZE = gbe_pkg::BUFFER_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [gbe_pkg::CMD_W-1:0]     req_command,
   input  logic [gbe_pkg::CHAR_W-1:0]    req_char_value,
   input  logic [gbe_pkg::FIELD_W-1:0]   req_move_count,
   output logic                          rsp_valid,
   output logic [gbe_pkg::CHAR_W-1:0]    rsp_under_cursor,
   output logic [gbe_pkg::FIELD_W-1:0]   rsp_cursor_pos,
   output logic [gbe_pkg::FIELD_W-1:0]   rsp_text_length,
   output logic                          rsp_is_dirty,
   output logic                          rsp_ignored
);

   localparam int PTR_W  = $clog2(BUFFER_SIZE + 1);
   localparam int ADDR_W = $clog2(BUFFER_SIZE);
   localparam int FW     = gbe_pkg::FIELD_W;
   localparam logic [PTR_W-1:0] SIZE_P  = PTR_W'(BUFFER_SIZE);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
   localparam logic [FW-1:0]    CNT_ONE = FW'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_STEP
   } state_type;

   state_type                     state_ff, state_in;
   gbe_pkg::command_type          cmd_ff, cmd_in, cmd_sel;
   logic [gbe_pkg::CHAR_W-1:0]    ch_ff, ch_in, ch_sel;
   logic [FW-1:0]                 cnt_ff, cnt_in, cnt_sel, cnt_dec;
   logic [PTR_W-1:0]              start_ff, start_in, end_ff, end_in;
   logic [PTR_W-1:0]              start_m1, start_p1, end_m1, end_p1;
   logic [gbe_pkg::CHAR_W-1:0]    cur_ff, cur_in, new_cur;
   logic                          dirty_ff, dirty_in;
   logic                          ign_ff, ign_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          active, go_left, edge_ok, stop_until;

   logic                          mem_we;
   logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
   logic [gbe_pkg::CHAR_W-1:0]    mem_wdata, mem_rdata;

   gbe_text_ram #(
      .DEPTH (BUFFER_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign start_m1 = start_ff - PTR_ONE;
   assign start_p1 = start_ff + PTR_ONE;
   assign end_m1   = end_ff - PTR_ONE;
   assign end_p1   = end_ff + PTR_ONE;
   assign cnt_dec  = cnt_ff - CNT_ONE;

   // Take the command from the ports on accept, from the held item otherwise
   assign active  = (state_ff == S_IDLE && start) || state_ff == S_EXEC;
   assign cmd_sel = (state_ff == S_IDLE) ? gbe_pkg::command_type'(req_command) : cmd_ff;
   assign ch_sel  = (state_ff == S_IDLE) ? req_char_value : ch_ff;
   assign cnt_sel = (state_ff == S_IDLE) ? req_move_count : cnt_ff;

   // Direction of the move in progress, and the byte it brings under the cursor
   assign go_left = cmd_ff inside {gbe_pkg::CMD_LEFT, gbe_pkg::CMD_LEFT_N,
                                   gbe_pkg::CMD_LEFT_UNTIL};
   assign new_cur = go_left ? mem_rdata :
                    ((end_p1 == SIZE_P) ? '0 : mem_rdata);
   assign edge_ok = go_left ? (start_m1 != '0) : (end_p1 != SIZE_P);
   assign stop_until = (new_cur == ch_ff) || (new_cur == '0) || !edge_ok;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      dirty_in     = dirty_ff;
      ign_in       = ign_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = start_ff[ADDR_W-1:0];
      mem_wdata    = ch_sel;
      mem_raddr    = start_m1[ADDR_W-1:0];

      // Latch the item on accept
      if (state_ff == S_IDLE && start) begin
         cmd_in = gbe_pkg::command_type'(req_command);
         ch_in  = req_char_value;
         cnt_in = req_move_count;
      end

      // Decode the command, or the next step of a move
      if (active) begin
         ign_in = 1'b0;
         case (cmd_sel)
            gbe_pkg::CMD_INSERT: begin
               if (start_ff != end_ff) begin
                  mem_we   = 1'b1;
                  start_in = start_p1;
                  dirty_in = 1'b1;
               end else begin
                  ign_in = 1'b1;
               end
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
            gbe_pkg::CMD_BACKSPACE: begin
               if (start_ff != '0) begin
                  start_in = start_m1;
                  dirty_in = 1'b1;
               end else begin
                  ign_in = 1'b1;
               end
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
            gbe_pkg::CMD_LEFT, gbe_pkg::CMD_LEFT_N, gbe_pkg::CMD_LEFT_UNTIL: begin
               mem_raddr = start_m1[ADDR_W-1:0];
               if (start_ff != '0 &&
                   (cmd_sel != gbe_pkg::CMD_LEFT_N || cnt_sel != '0)) begin
                  state_in = S_STEP;
               end else begin
                  ign_in       = (cmd_sel == gbe_pkg::CMD_LEFT);
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
            gbe_pkg::CMD_RIGHT, gbe_pkg::CMD_RIGHT_N, gbe_pkg::CMD_RIGHT_UNTIL: begin
               mem_raddr = end_p1[ADDR_W-1:0];
               if (end_ff != SIZE_P &&
                   (cmd_sel != gbe_pkg::CMD_RIGHT_N || cnt_sel != '0)) begin
                  state_in = S_STEP;
               end else begin
                  ign_in       = (cmd_sel == gbe_pkg::CMD_RIGHT);
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
            gbe_pkg::CMD_CLEAR_DIRTY: begin
               dirty_in     = 1'b0;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
            default: begin
               ign_in       = 1'b1;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      // Carry one byte across the gap and decide whether to go on
      if (state_ff == S_STEP) begin
         mem_we = 1'b1;
         if (go_left) begin
            mem_waddr = end_m1[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            start_in  = start_m1;
            end_in    = end_m1;
         end else begin
            mem_waddr = start_ff[ADDR_W-1:0];
            mem_wdata = cur_ff;
            start_in  = start_p1;
            end_in    = end_p1;
         end
         cur_in = new_cur;
         cnt_in = cnt_dec;
         case (cmd_ff)
            gbe_pkg::CMD_LEFT_N, gbe_pkg::CMD_RIGHT_N: begin
               if (cnt_dec != '0 && edge_ok) begin
                  state_in = S_EXEC;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
            gbe_pkg::CMD_LEFT_UNTIL, gbe_pkg::CMD_RIGHT_UNTIL: begin
               if (!stop_until) begin
                  state_in = S_EXEC;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
            default: begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         end_ff       <= SIZE_P;
         cur_ff       <= '0;
         dirty_ff     <= 1'b0;
         ign_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         cur_ff       <= cur_in;
         dirty_ff     <= dirty_in;
         ign_ff       <= ign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      ch_ff  <= ch_in;
      cnt_ff <= cnt_in;
   end

   // Drive the result ports, resizing pointers to the field width
   logic [PTR_W-1:0]    len_ptr;
   logic [PTR_W+FW-1:0] pos_wide, len_wide;

   assign len_ptr  = SIZE_P - (end_ff - start_ff);
   assign pos_wide = {{FW{1'b0}}, start_ff};
   assign len_wide = {{FW{1'b0}}, len_ptr};

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_under_cursor = cur_ff;
   assign rsp_cursor_pos   = pos_wide[FW-1:0];
   assign rsp_text_length  = len_wide[FW-1:0];
   assign rsp_is_dirty     = dirty_ff;
   assign rsp_ignored      = ign_ff;

`ifndef SYNTHESIS
   // The gap never turns negative
   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      start_ff <= end_ff)
      else $error("gap start passed gap end");

   // A result only follows an accepted item or work in progress
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || start))
      else $error("result without an item");

   // A result is shown only while a new item can be taken
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result shown while busy");

   // Cursor steps keep the gap width
   a_step_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |=> (end_ff - start_ff) == $past(end_ff - start_ff))
      else $error("cursor step changed the text length");

   // The dirty flag rises only on an edit
   a_dirty_edit: assert property (@(posedge clock) disable iff (reset)
      $rose(dirty_ff) |-> rsp_valid_ff &&
         (cmd_ff == gbe_pkg::CMD_INSERT || cmd_ff == gbe_pkg::CMD_BACKSPACE))
      else $error("dirty flag set without an edit");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int STORE_DEPTH = gbe_pkg::BUFFER_SIZE_DEF;
   localparam int CMD_W       = gbe_pkg::CMD_W;
   localparam int CHAR_W      = gbe_pkg::CHAR_W;
   localparam int FIELD_W     = gbe_pkg::FIELD_W;

   // Codes past the last command, all ignored by the block
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

   typedef struct packed {
      logic [CHAR_W-1:0]  under;
      logic [FIELD_W-1:0] pos;
      logic [FIELD_W-1:0] len;
      logic               dirty;
      logic               ignored;
   } cursor_report_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [CHAR_W-1:0]  ch;
      logic [FIELD_W-1:0] cnt;
      logic               typed;
      cursor_report_type  want;
   } edit_row_type;

   typedef enum {PH_MIXED, PH_FILL, PH_FULL, PH_DRAIN} stim_phase_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [CHAR_W-1:0]   req_char_value;
   logic [FIELD_W-1:0]  req_move_count;
   logic                rsp_valid;
   logic [CHAR_W-1:0]   rsp_under_cursor;
   logic [FIELD_W-1:0]  rsp_cursor_pos;
   logic [FIELD_W-1:0]  rsp_text_length;
   logic                rsp_is_dirty;
   logic                rsp_ignored;

   gap_buffer_editor #(.BUFFER_SIZE(STORE_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_char_value   (req_char_value),
      .req_move_count   (req_move_count),
      .rsp_valid        (rsp_valid),
      .rsp_under_cursor (rsp_under_cursor),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_text_length  (rsp_text_length),
      .rsp_is_dirty     (rsp_is_dirty),
      .rsp_ignored      (rsp_ignored)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Shadow copy of the text store and the gap
   logic [CHAR_W-1:0] text_mem [STORE_DEPTH];
   int unsigned       gap_lo;
   int unsigned       gap_hi;
   bit                text_dirty;

   cursor_report_type pending_reports [$];
   int                mismatches;
   int                burst_left;
   edit_row_type      directed_rows [25];

   function automatic void empty_text();
      for (int i = 0; i < STORE_DEPTH; i++) text_mem[i] = '0;
      gap_lo     = 0;
      gap_hi     = STORE_DEPTH;
      text_dirty = 1'b0;
   endfunction

   function automatic logic [CHAR_W-1:0] byte_under();
      if (gap_hi >= STORE_DEPTH) return '0;
      return text_mem[gap_hi];
   endfunction

   // Carry one byte from the left part across the gap
   function automatic bit carry_left();
      if (gap_lo == 0 || gap_hi == 0) return 1'b0;
      gap_lo--;
      gap_hi--;
      text_mem[gap_hi] = text_mem[gap_lo];
      return 1'b1;
   endfunction

   // Carry one byte from the right part across the gap
   function automatic bit carry_right();
      if (gap_hi >= STORE_DEPTH || gap_lo >= STORE_DEPTH) return 1'b0;
      text_mem[gap_lo] = text_mem[gap_hi];
      gap_lo++;
      gap_hi++;
      return 1'b1;
   endfunction

   // Apply one edit to the shadow store and report the cursor state
   function automatic cursor_report_type apply_edit(logic [CMD_W-1:0] cmd,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [FIELD_W-1:0] cnt);
      cursor_report_type rep;
      bit                ign;
      logic [CHAR_W-1:0] b;
      ign = 1'b0;
      case (cmd)
         gbe_pkg::CMD_INSERT: begin
            if (gap_lo < gap_hi && gap_lo < STORE_DEPTH) begin
               text_mem[gap_lo] = ch;
               gap_lo++;
               text_dirty = 1'b1;
            end else begin
               ign = 1'b1;
            end
         end
         gbe_pkg::CMD_BACKSPACE: begin
            if (gap_lo > 0) begin
               gap_lo--;
               text_dirty = 1'b1;
            end else begin
               ign = 1'b1;
            end
         end
         gbe_pkg::CMD_LEFT:  ign = !carry_left();
         gbe_pkg::CMD_RIGHT: ign = !carry_right();
         gbe_pkg::CMD_LEFT_N: begin
            for (int i = 0; i < cnt; i++) if (!carry_left()) break;
         end
         gbe_pkg::CMD_RIGHT_N: begin
            for (int i = 0; i < cnt; i++) if (!carry_right()) break;
         end
         gbe_pkg::CMD_LEFT_UNTIL: begin
            while (gap_lo > 0) begin
               if (!carry_left()) break;
               b = byte_under();
               if (b == ch || b == '0) break;
            end
         end
         gbe_pkg::CMD_RIGHT_UNTIL: begin
            while (gap_hi < STORE_DEPTH) begin
               if (!carry_right()) break;
               b = byte_under();
               if (b == ch || b == '0) break;
            end
         end
         gbe_pkg::CMD_CLEAR_DIRTY: text_dirty = 1'b0;
         default: ign = 1'b1;
      endcase
      rep.under   = byte_under();
      rep.pos     = FIELD_W'(gap_lo);
      rep.len     = FIELD_W'(STORE_DEPTH - (gap_hi - gap_lo));
      rep.dirty   = text_dirty;
      rep.ignored = ign;
      return rep;
   endfunction

   // Pick a command; weights are listed in command code order, unknown last
   function automatic logic [CMD_W-1:0] pick_command(stim_phase_type ph);
      int w [10];
      int r;
      int acc;
      case (ph)
         PH_MIXED: w = '{35, 10, 10, 10, 8, 8, 6, 6, 4, 3};
         PH_FILL:  w = '{88, 0, 2, 2, 2, 2, 2, 2, 0, 0};
         PH_FULL:  w = '{40, 0, 10, 10, 8, 8, 8, 8, 4, 4};
         default:  w = '{20, 40, 6, 6, 6, 6, 6, 6, 2, 2};
      endcase
      r   = $urandom_range(0, 99);
      acc = 0;
      for (int i = 0; i < 10; i++) begin
         acc += w[i];
         if (r < acc) begin
            if (i == 9) return CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            return CMD_W'(i);
         end
      end
      return gbe_pkg::CMD_INSERT;
   endfunction

   // Mostly a small alphabet so that until moves find their delimiter
   function automatic logic [CHAR_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return CHAR_W'($urandom_range(8'h61, 8'h68));
      if (r < 70) return '0;
      return CHAR_W'($urandom());
   endfunction

   // Keep most counted moves short; the full count only now and then
   function automatic logic [FIELD_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return FIELD_W'($urandom_range(0, 12));
      if (r < 93) return FIELD_W'($urandom_range(13, 200));
      if (r < 97) return FIELD_W'(STORE_DEPTH);
      return FIELD_W'($urandom_range(0, STORE_DEPTH));
   endfunction

   // Drive one item at the falling edge and hold it until accepted
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                            logic [FIELD_W-1:0] cnt, logic typed,
                            cursor_report_type want);
      int                gap;
      cursor_report_type got;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 24);
         start = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 48);
      end
      start          = 1'b1;
      req_command    = cmd;
      req_char_value = ch;
      req_move_count = cnt;
      do @(posedge clock); while (busy);
      got = apply_edit(cmd, ch, cnt);
      pending_reports.push_back(typed ? want : got);
      @(negedge clock);
      burst_left--;
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic await_reports();
      start      = 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic random_phase(stim_phase_type ph, int items);
      for (int i = 0; i < items; i++)
         send_item(pick_command(ph), pick_byte(), pick_count(), 1'b0, '0);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            $display("%0t unexpected result: expected none, actual pos %0d len %0d",
                     $time, rsp_cursor_pos, rsp_text_length);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("under_cursor", 16'(want.under), 16'(rsp_under_cursor));
            check_field("cursor_pos", 16'(want.pos), 16'(rsp_cursor_pos));
            check_field("text_length", 16'(want.len), 16'(rsp_text_length));
            check_field("is_dirty", 16'(want.dirty), 16'(rsp_is_dirty));
            check_field("ignored", 16'(want.ignored), 16'(rsp_ignored));
         end
      end
   end

   initial begin
      #(300_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = gbe_pkg::CMD_INSERT;
      req_char_value = '0;
      req_move_count = '0;
      mismatches     = 0;
      burst_left     = 0;
      empty_text();

      // Edges and unknown codes on the empty text, then a short text to walk
      directed_rows = '{
         '{gbe_pkg::CMD_LEFT,  8'h00, 11'd0, 1'b1, '{8'h00, 11'd0, 11'd0, 1'b0, 1'b1}},
         '{gbe_pkg::CMD_RIGHT, 8'h00, 11'd0, 1'b1, '{8'h00, 11'd0, 11'd0, 1'b0, 1'b1}},
         '{gbe_pkg::CMD_BACKSPACE, 8'h00, 11'd0, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b1}},
         '{gbe_pkg::CMD_LEFT_N, 8'h00, 11'd5, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b0}},
         '{gbe_pkg::CMD_RIGHT_N, 8'h00, 11'd1024, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b0}},
         '{gbe_pkg::CMD_LEFT_UNTIL, 8'h61, 11'd0, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b0}},
         '{gbe_pkg::CMD_RIGHT_UNTIL, 8'h00, 11'd0, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b0}},
         '{gbe_pkg::CMD_CLEAR_DIRTY, 8'h00, 11'd0, 1'b1,
           '{8'h00, 11'd0, 11'd0, 1'b0, 1'b0}},
         '{CMD_UNKNOWN_LO, 8'hff, 11'd2047, 1'b1, '{8'h00, 11'd0, 11'd0, 1'b0, 1'b1}},
         '{CMD_UNKNOWN_HI, 8'h00, 11'd0,    1'b1, '{8'h00, 11'd0, 11'd0, 1'b0, 1'b1}},
         '{gbe_pkg::CMD_INSERT, 8'h41, 11'd0, 1'b1, '{8'h00, 11'd1, 11'd1, 1'b1, 1'b0}},
         '{gbe_pkg::CMD_INSERT, 8'hff, 11'd0, 1'b1, '{8'h00, 11'd2, 11'd2, 1'b1, 1'b0}},
         '{gbe_pkg::CMD_INSERT, 8'h00, 11'd0, 1'b1, '{8'h00, 11'd3, 11'd3, 1'b1, 1'b0}},
         '{gbe_pkg::CMD_INSERT, 8'h42, 11'd0, 1'b1, '{8'h00, 11'd4, 11'd4, 1'b1, 1'b0}},
         '{gbe_pkg::CMD_INSERT,      8'h43, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_LEFT,        8'h00, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_LEFT_N,      8'h00, 11'd2,    1'b0, '0},
         '{gbe_pkg::CMD_LEFT_UNTIL,  8'hff, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_RIGHT_UNTIL, 8'h43, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_LEFT_UNTIL,  8'h00, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_RIGHT_N,     8'h00, 11'd1024, 1'b0, '0},
         '{gbe_pkg::CMD_RIGHT,       8'h00, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_LEFT_N,      8'h00, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_BACKSPACE,   8'h00, 11'd0,    1'b0, '0},
         '{gbe_pkg::CMD_CLEAR_DIRTY, 8'h00, 11'd0,    1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].cnt,
                   directed_rows[i].typed, directed_rows[i].want);
      await_reports();

      random_phase(PH_MIXED, 100);

      // Grow the text until the gap closes, then hammer the full store
      while (gap_hi != gap_lo)
         send_item(pick_command(PH_FILL), pick_byte(), pick_count(), 1'b0, '0);
      await_reports();
      random_phase(PH_FULL, 40);
      await_reports();

      random_phase(PH_DRAIN, 100);

      await_reports();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
